// ===== src/hsvh_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvh_pkg
// Shared types, constants and the hue band function of the HSV color histogram.
// ----------------------------------------------------------------------------
package hsvh_pkg;

   localparam int NUM_BINS          = 72;
   localparam int BIN_BITS          = 7;
   localparam int HUE_BITS          = 9;
   localparam int CLASS_BITS        = 2;
   localparam int COLOR_BITS        = 8;
   localparam int DIVIDEND_BITS     = 18;
   localparam int DIVISOR_BITS      = 9;
   localparam int STEP_BITS         = 4;
   localparam int REPORT_BITS       = 32;
   localparam int DEFAULT_COUNT_BITS = 32;
   localparam int REQ_DATA_BITS     = 32;
   localparam int RSP_DATA_BITS     = 56;

   localparam logic [0:0] OP_PIXEL = 1'b0;
   localparam logic [0:0] OP_READ  = 1'b1;

   typedef struct packed {
      logic                 load;
      logic                 calc;
      logic                 div_step;
      logic [STEP_BITS-1:0] div_idx;
      logic                 lookup;
      logic                 write;
      logic                 push;
   } cmd_type;

   typedef struct packed {
      logic is_read;
      logic out_free;
   } status_type;

   function automatic logic [2:0] hue_band(input logic [HUE_BITS-1:0] h);
      logic [2:0] band;
      if (h >= 9'd316 || h <= 9'd20) band = 3'd0;
      else if (h <= 9'd40)  band = 3'd1;
      else if (h <= 9'd75)  band = 3'd2;
      else if (h <= 9'd155) band = 3'd3;
      else if (h <= 9'd190) band = 3'd4;
      else if (h <= 9'd270) band = 3'd5;
      else if (h <= 9'd295) band = 3'd6;
      else band = 3'd7;
      return band;
   endfunction

endpackage

// ===== src/rgb_hsv_quantized_histogram.sv =====
// ----------------------------------------------------------------------------
// rgb_hsv_quantized_histogram
// 72-bin HSV color histogram with saturating counters and read-and-clear.
// ----------------------------------------------------------------------------
// Input channel req_*: one word per item. tuser = 0 accumulates the pixel in
// tdata, tuser = 1 reads and clears the bin named by bin_select.
// Result channel rsp_*: one word per item, in order.
// An accumulate word passes these steps after acceptance: max/min and the hue
// numerator, the restoring hue divider (one quotient bit per step), the bin
// lookup, the counter write and the load of the output register. A read word
// skips the numerator and the divider.
// The next word is accepted no earlier than the cycle after the result is
// loaded, so the block takes no new word while one is still in process.
// Reset marks all 72 counters empty at once and empties the output register.
// While the receiver stalls, the result holds and the block can take and
// process one more word; it then waits until the output register frees.
// ----------------------------------------------------------------------------
module rgb_hsv_quantized_histogram #(
   parameter int COUNT_BITS = hsvh_pkg::DEFAULT_COUNT_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // red[7:0], green[15:8], blue[23:16], bin_select[30:24], zero[31]
   input  logic [hsvh_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // op[0]
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // hue_degrees[8:0], sat_class[10:9], val_class[12:11], bin_number[19:13],
   // bin_count[51:20], zero[55:52]
   output logic [hsvh_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import hsvh_pkg::*;

   cmd_type    cmd;
   status_type status;

   hsvh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hsvh_datapath #(.COUNT_BITS(COUNT_BITS)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== src/hsvh_ctrl.sv =====
// ----------------------------------------------------------------------------
// hsvh_ctrl
// Sequencer of the histogram: conversion, division steps, bin update, push.
// ----------------------------------------------------------------------------
module hsvh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  hsvh_pkg::status_type status,
   output hsvh_pkg::cmd_type    cmd
);
   import hsvh_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CALC, ST_DIV, ST_LOOKUP, ST_WRITE, ST_PUSH
   } state_type;

   state_type            state_ff, state_in;
   logic [STEP_BITS-1:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.div_idx = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (status.is_read) begin
               state_in = ST_LOOKUP;
            end else begin
               cmd.calc = 1'b1;
               idx_in   = STEP_BITS'(HUE_BITS - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (idx_ff == '0) state_in = ST_LOOKUP;
            else idx_in = idx_ff - 1'b1;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_PUSH;
         end
         ST_PUSH: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== src/hsvh_datapath.sv =====
// ----------------------------------------------------------------------------
// hsvh_datapath
// HSV conversion, restoring hue divider, counter store and output register.
// ----------------------------------------------------------------------------
module hsvh_datapath #(
   parameter int COUNT_BITS = hsvh_pkg::DEFAULT_COUNT_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  hsvh_pkg::cmd_type                    cmd,
   output hsvh_pkg::status_type                 status,
   input  logic [hsvh_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [hsvh_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);
   import hsvh_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic                      op_ff;
   logic [COLOR_BITS-1:0]     red_ff, green_ff, blue_ff;
   logic [BIN_BITS-1:0]       sel_ff;
   logic [DIVIDEND_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]   den_ff;
   logic [HUE_BITS-1:0]       quo_ff, quo_in;
   logic [CLASS_BITS-1:0]     sat_ff, val_ff;
   logic [HUE_BITS-1:0]       hue_ff;
   logic [BIN_BITS-1:0]       bin_ff;
   logic                      bin_ok_ff;
   logic [COUNT_BITS-1:0]     mem_q_ff;
   logic [NUM_BINS-1:0]       valid_ff;
   logic [COUNT_BITS-1:0]     store [NUM_BINS];
   logic [REPORT_BITS-1:0]    count_ff;
   logic                      out_valid_ff;
   logic [RSP_DATA_BITS-1:0]  out_data_ff;

   logic [COLOR_BITS-1:0]     mx, mn, d;
   logic [DIVIDEND_BITS:0]    t;
   logic [DIVIDEND_BITS-1:0]  den_sh;
   logic [HUE_BITS-1:0]       hue;
   logic [BIN_BITS-1:0]       bin;
   logic [CLASS_BITS-1:0]     sc, vc;

   assign status.is_read  = (op_ff == OP_READ);
   assign status.out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      mx = red_ff;
      mn = red_ff;
      if (green_ff > mx) mx = green_ff;
      if (blue_ff > mx)  mx = blue_ff;
      if (green_ff < mn) mn = green_ff;
      if (blue_ff < mn)  mn = blue_ff;
      d = mx - mn;
      if (red_ff == mx) begin
         if (green_ff >= blue_ff)
            t = 19'd60 * 19'(green_ff - blue_ff);
         else
            t = 19'd360 * 19'(d) - 19'd60 * 19'(blue_ff - green_ff);
      end else if (green_ff == mx) begin
         t = 19'd120 * 19'(d) + 19'd60 * 19'(blue_ff) - 19'd60 * 19'(red_ff);
      end else begin
         t = 19'd240 * 19'(d) + 19'd60 * 19'(red_ff) - 19'd60 * 19'(green_ff);
      end
      if (mx == '0 || 11'd5 * 11'(d) <= 11'(mx)) sc = 2'd0;
      else if (12'd10 * 12'(d) < 12'd7 * 12'(mx)) sc = 2'd1;
      else sc = 2'd2;
      if (mx <= 8'd51) vc = 2'd0;
      else if (mx <= 8'd178) vc = 2'd1;
      else vc = 2'd2;
   end

   always_comb begin
      den_sh = DIVIDEND_BITS'(den_ff) << cmd.div_idx;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (rem_ff >= den_sh) begin
         rem_in = rem_ff - den_sh;
         quo_in[cmd.div_idx] = 1'b1;
      end
      hue = (quo_ff > 9'd359) ? quo_ff - 9'd360 : quo_ff;
      bin = BIN_BITS'(7'(hue_band(hue)) * 7'd9 + 7'(sat_ff) * 7'd3 + 7'(val_ff));
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_tuser;
         red_ff   <= req_tdata[7:0];
         green_ff <= req_tdata[15:8];
         blue_ff  <= req_tdata[23:16];
         sel_ff   <= req_tdata[30:24];
         quo_ff   <= '0;
         sat_ff   <= '0;
         val_ff   <= '0;
         den_ff   <= '0;
      end
      if (cmd.calc) begin
         rem_ff <= DIVIDEND_BITS'(2'd2 * t + 19'(d));
         den_ff <= {d, 1'b0};
         sat_ff <= sc;
         val_ff <= vc;
      end
      if (cmd.div_step && den_ff != '0) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.lookup) begin
         if (op_ff == OP_READ) begin
            bin_ff    <= sel_ff;
            hue_ff    <= '0;
            bin_ok_ff <= (sel_ff < BIN_BITS'(NUM_BINS));
         end else begin
            bin_ff    <= bin;
            hue_ff    <= hue;
            bin_ok_ff <= 1'b1;
         end
      end
      if (cmd.write) begin
         count_ff <= '0;
         if (bin_ok_ff && op_ff == OP_READ && valid_ff[bin_ff])
            count_ff <= REPORT_BITS'(mem_q_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         mem_q_ff <= store[(op_ff == OP_READ) ? sel_ff : bin];
      end
      if (cmd.write && bin_ok_ff) begin
         if (op_ff == OP_READ) store[bin_ff] <= '0;
         else if (!valid_ff[bin_ff]) store[bin_ff] <= COUNT_BITS'(1);
         else if (mem_q_ff != COUNT_MAX) store[bin_ff] <= mem_q_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.write && bin_ok_ff) valid_ff[bin_ff] <= 1'b1;
         if (cmd.push) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         out_data_ff <= {4'd0, count_ff, bin_ff, val_ff, sat_ff, hue_ff};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

`ifndef SYNTHESIS
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_data_ff[8:0] <= 9'd359)
      else $error("hue out of range");
   a_class_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff[10:9] != 2'd3 && out_data_ff[12:11] != 2'd3))
      else $error("class code out of range");
   a_pixel_count: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff[8:0] != '0) |-> out_data_ff[51:20] == '0)
      else $error("pixel result carries a count");
   a_push_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> out_valid_ff)
      else $error("push lost");
`endif

endmodule

// ===== bench/rgb_hsv_quantized_histogram_chk.sv =====
// ----------------------------------------------------------------------------
// rgb_hsv_quantized_histogram_chk
// Watches both streams of the HSV histogram, predicts each result word from
// the accepted request words and compares it field by field, in order.
// ----------------------------------------------------------------------------
module rgb_hsv_quantized_histogram_chk (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [hsvh_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                               req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [hsvh_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output int                                 fail_count,
   output int                                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import hsvh_pkg::*;

   typedef struct packed {
      logic [31:0] count;
      logic [6:0]  bin;
      logic [1:0]  vcls;
      logic [1:0]  scls;
      logic [8:0]  hue;
   } hsv_word_type;

   logic [31:0]  bin_counts [NUM_BINS];
   hsv_word_type want_q [$];

   function automatic logic [2:0] band_of(input int h);
      if (h >= 316 || h <= 20) return 3'd0;
      if (h <= 40) return 3'd1;
      if (h <= 75) return 3'd2;
      if (h <= 155) return 3'd3;
      if (h <= 190) return 3'd4;
      if (h <= 270) return 3'd5;
      if (h <= 295) return 3'd6;
      return 3'd7;
   endfunction

   function automatic hsv_word_type classify_pixel(input int r, input int g, input int b);
      hsv_word_type w;
      int mx, mn, d, t, h;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      h = 0;
      if (d != 0) begin
         if (r == mx) t = (g >= b) ? 60 * (g - b) : 360 * d + 60 * (g - b);
         else if (g == mx) t = 120 * d + 60 * (b - r);
         else t = 240 * d + 60 * (r - g);
         if (t < 0) t = 0;
         h = (2 * t + d) / (2 * d);
         if (h > 359) h -= 360;
      end
      w = '0;
      w.hue = 9'(h);
      w.scls = 2'((mx == 0 || 5 * d <= mx) ? 0 : (10 * d < 7 * mx) ? 1 : 2);
      w.vcls = 2'((mx <= 51) ? 0 : (mx <= 178) ? 1 : 2);
      w.bin = 7'(band_of(h) * 9 + w.scls * 3 + w.vcls);
      return w;
   endfunction

   assign pending_count = want_q.size();

   always @(posedge clock) begin
      hsv_word_type w, got;
      if (reset) begin
         foreach (bin_counts[i]) bin_counts[i] <= '0;
         want_q.delete();
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_READ) begin
               w = '0;
               w.bin = req_tdata[30:24];
               if (req_tdata[30:24] < NUM_BINS) begin
                  w.count = bin_counts[req_tdata[30:24]];
                  bin_counts[req_tdata[30:24]] = '0;
               end
            end else begin
               w = classify_pixel(req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]);
               if (bin_counts[w.bin] != 32'hFFFF_FFFF)
                  bin_counts[w.bin] = bin_counts[w.bin] + 1;
            end
            want_q = {want_q, w};
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[51:0];
            if (want_q.size() == 0) begin
               $error("unexpected result word %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               w = want_q.pop_front();
               if (got !== w || rsp_tdata[55:52] !== 4'd0) begin
                  fail_count <= fail_count + 1;
                  if (got.hue !== w.hue)
                     $error("hue_degrees exp %0d got %0d", w.hue, got.hue);
                  if (got.scls !== w.scls)
                     $error("sat_class exp %0d got %0d", w.scls, got.scls);
                  if (got.vcls !== w.vcls)
                     $error("val_class exp %0d got %0d", w.vcls, got.vcls);
                  if (got.bin !== w.bin)
                     $error("bin_number exp %0d got %0d", w.bin, got.bin);
                  if (got.count !== w.count)
                     $error("bin_count exp %0d got %0d", w.count, got.count);
                  if (rsp_tdata[55:52] !== 4'd0)
                     $error("pad exp 0 got %h", rsp_tdata[55:52]);
               end
            end
         end
      end
   end
endmodule

// ===== bench/rgb_hsv_quantized_histogram_tb.sv =====
// ----------------------------------------------------------------------------
// rgb_hsv_quantized_histogram_tb
// Drives pixel and read-and-clear words into the HSV histogram under several
// flow-control phases and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module rgb_hsv_quantized_histogram_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hsvh_pkg::*;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata = '0;
   logic                      req_tuser = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   int                        fail_count, pending_count;
   int                        send_idle, recv_idle, pixels_sent, reads_sent;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   rgb_hsv_quantized_histogram uut (.*);
   rgb_hsv_quantized_histogram_chk checker_i (.*);

   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle);

   task automatic send_word(input logic op, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [6:0] sel);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, sel, b, g, r};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_READ) reads_sent++;
      else pixels_sent++;
   endtask

   task automatic send_pixel(input int r, input int g, input int b);
      send_word(OP_PIXEL, 8'(r), 8'(g), 8'(b), 7'($urandom));
   endtask

   task automatic send_read(input int sel);
      send_word(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 7'(sel));
   endtask

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int k;
      send_idle = 0; recv_idle = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_pixel(0, 0, 0);
      send_pixel(255, 255, 255);
      send_pixel(255, 0, 0);
      send_pixel(0, 255, 0);
      send_pixel(0, 0, 255);
      send_pixel(255, 0, 1);
      send_pixel(255, 255, 0);
      send_pixel(255, 0, 255);
      send_pixel(51, 40, 41);
      send_pixel(52, 52, 20);
      send_pixel(178, 54, 100);
      send_pixel(179, 179, 144);
      send_pixel(100, 70, 30);
      send_pixel(10, 0, 1);
      send_read(0);
      send_read(0);
      send_read(71);
      send_read(72);
      send_read(127);
      send_read(2);
      for (k = 0; k < 520; k++) begin
         case (k / 130)
            0: begin send_idle = 0;  recv_idle = 0;  end
            1: begin send_idle = 53; recv_idle = 0;  end
            2: begin send_idle = 0;  recv_idle = 53; end
            default: begin send_idle = 9; recv_idle = 9; end
         endcase
         if ($urandom_range(99) < 15)
            send_read($urandom_range(99) < 90 ? $urandom_range(71) : $urandom_range(127));
         else if ($urandom_range(99) < 10)
            send_pixel($urandom_range(3) * 85, $urandom_range(3) * 85,
                       $urandom_range(3) * 85);
         else
            send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
      end
      send_idle = 0;
      for (k = 0; k < NUM_BINS; k++) send_read(k);
      req_tvalid <= 1'b0;
      recv_idle = 0;
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d pixel words and %0d read words across four flow-control phases.",
               pixels_sent, reads_sent);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
